>>> design/bxds_pkg.sv
`default_nettype none

package bxds_pkg;

    // Channels per pixel and bits per sample.
    localparam int NCH   = 4;
    localparam int PIX_W = 8;

    // Defaults for the top-level sizing parameters.
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_MAX_SCALE  = 16;

    // Stream payload widths.
    localparam int IN_W      = NCH * PIX_W;
    localparam int OUT_COL_W = 11;
    localparam int OUT_ROW_W = 12;
    localparam int OUT_W     = 56;

    // Configuration register widths.
    localparam int SX_W = 5;
    localparam int SY_W = 5;
    localparam int IW_W = 12;
    localparam int IH_W = 13;
    localparam int NC_W = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;

    // Register reset values.
    localparam logic [SX_W-1:0] RST_SCALE_X       = 5'd2;
    localparam logic [SY_W-1:0] RST_SCALE_Y       = 5'd2;
    localparam logic [IW_W-1:0] RST_IMAGE_WIDTH   = 12'd640;
    localparam logic [IH_W-1:0] RST_IMAGE_HEIGHT  = 13'd480;
    localparam logic [NC_W-1:0] RST_CHANNEL_COUNT = 3'd3;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

>>> design/bxds_colmem.sv
`default_nettype none

module bxds_colmem #(
    parameter int DEPTH  = bxds_pkg::DEF_MAX_WIDTH,
    parameter int DATA_W = 64
) (
    input  wire logic                     aclk,
    input  wire bxds_pkg::mem_ctl_t       ctl,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wdata,
    output logic      [DATA_W-1:0]        rdata
);
    import bxds_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wdata;
        end
        if (ctl.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/bxds_div.sv
`default_nettype none

module bxds_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 9
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          start,
    input  wire logic [bxds_pkg::NCH-1:0][NUM_W-1:0]           num,
    input  wire logic [DEN_W-1:0]                              den,
    output bxds_pkg::div_stat_t                                stat,
    output logic      [bxds_pkg::NCH-1:0][bxds_pkg::PIX_W-1:0] mean
);
    import bxds_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0]              cnt_reg;
    logic                          done_reg;
    logic [DEN_W-1:0]              den_reg;
    logic [NCH-1:0][DEN_W-1:0]     rem_reg;
    logic [NCH-1:0][NUM_W-1:0]     quo_reg;
    logic [NCH-1:0][DEN_W-1:0]     rem_next;
    logic [NCH-1:0][NUM_W-1:0]     quo_next;
    logic [DEN_W:0]                shifted;

    // One restoring step per cycle in each lane; the numerator shifts out of
    // the quotient register as the quotient bits shift in.
    always_comb begin
        shifted = '0;
        for (int c = 0; c < NCH; c++) begin
            shifted = {rem_reg[c], quo_reg[c][NUM_W-1]};
            if (shifted >= {1'b0, den_reg}) begin
                rem_next[c] = DEN_W'(shifted - {1'b0, den_reg});
                quo_next[c] = {quo_reg[c][NUM_W-2:0], 1'b1};
            end else begin
                rem_next[c] = shifted[DEN_W-1:0];
                quo_next[c] = {quo_reg[c][NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start) begin
                cnt_reg <= CNT_W'(NUM_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= num;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // Means above full scale saturate.
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            if (quo_reg[c] > NUM_W'({PIX_W{1'b1}})) begin
                mean[c] = {PIX_W{1'b1}};
            end else begin
                mean[c] = quo_reg[c][PIX_W-1:0];
            end
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

`default_nettype wire

>>> design/box_average_downscaler_core.sv
// Channel  Direction  Beat contents
// s_       in         one pixel: chan0..chan3 in s_tdata
// m_       out        one block mean: mean0..mean3, out_col, out_row in m_tdata,
//                     frame_end on m_tlast
// cfg_     in         register write: cfg_index selects, cfg_data carries the value
//
// A pixel that does not close a block segment does not stall the input. A pixel that
// closes a segment stalls it for the write-back: the column sum is read from the column
// memory, then the new sum is written back. A pixel that completes a block stalls it for
// the read and the write-back, the bit-serial divider at one quotient bit per cycle and
// its registered done flag, and the load of the output register, delayed while an
// earlier mean still waits there. A finished mean waits in the output register while
// further pixels are taken. Reset clears the counters, the segment sums, the sequencer
// and the output register; the column memory is not cleared, as every entry is written
// on the first row of its block before it is read.

`default_nettype none

module box_average_downscaler_core #(
    parameter int MAX_WIDTH  = bxds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bxds_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_SCALE  = bxds_pkg::DEF_MAX_SCALE
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Pixel input. s_tdata, from bit 0: chan0, chan1, chan2, chan3.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bxds_pkg::IN_W-1:0]       s_tdata,
    // Mean output. m_tdata, from bit 0: mean0, mean1, mean2, mean3, out_col,
    // out_row, one zero pad bit.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [bxds_pkg::OUT_W-1:0]      m_tdata,
    output logic                                 m_tlast,
    // Register writes.
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bxds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bxds_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bxds_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int PW     = $clog2(MAX_SCALE);
    localparam int PSUM_W = PIX_W + PW;
    localparam int CSUM_W = PIX_W + 2 * PW;
    localparam int DV_W   = 2 * PW + 1;
    localparam int MEM_W  = NCH * CSUM_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } state_t;

    // Configuration registers.
    logic [SX_W-1:0] scale_x_reg;
    logic [SY_W-1:0] scale_y_reg;
    logic [IW_W-1:0] image_width_reg;
    logic [IH_W-1:0] image_height_reg;
    logic [NC_W-1:0] channel_count_reg;

    // Limits after clamping, stored minus one; the channel count is stored as is.
    logic [PW-1:0]   sx_m1;
    logic [PW-1:0]   sy_m1;
    logic [CW-1:0]   w_m1;
    logic [RW-1:0]   h_m1;
    logic [NC_W-1:0] nc_cl;

    // Position counters and running segment sums.
    logic [CW-1:0]                  pix_col_reg;
    logic [RW-1:0]                  pix_row_reg;
    logic [PW-1:0]                  ph_col_reg;
    logic [PW-1:0]                  ph_row_reg;
    logic [CW-1:0]                  blk_col_reg;
    logic [RW-1:0]                  blk_row_reg;
    logic [NCH-1:0][PSUM_W-1:0]     part_reg;
    logic [NCH-1:0][PSUM_W-1:0]     part_sum;

    // Values held for the segment being folded into the column memory.
    logic [CW-1:0]                  col_l_reg;
    logic                           first_row_reg;
    logic                           vert_reg;
    logic [DV_W-1:0]                n_reg;
    logic [OUT_COL_W-1:0]           out_col_l_reg;
    logic [OUT_ROW_W-1:0]           out_row_l_reg;
    logic                           fend_l_reg;
    logic [NCH-1:0][PSUM_W-1:0]     seg_sum_reg;

    logic                           accept;
    logic                           row_end;
    logic                           seg_end;
    logic                           vert_end;
    logic                           frame_end;
    logic [PW:0]                    cnt_x;
    logic [PW:0]                    cnt_y;
    logic [DV_W-1:0]                n_now;

    state_t                         state_reg;
    state_t                         state_next;
    logic                           m_tvalid_reg;
    logic [OUT_W-1:0]               m_data_reg;
    logic                           m_last_reg;
    logic [OUT_W-1:0]               out_word;

    mem_ctl_t                       mem_ctl;
    logic [MEM_W-1:0]               mem_rdata;
    logic [NCH-1:0][CSUM_W-1:0]     col_old;
    logic [NCH-1:0][CSUM_W-1:0]     col_new;

    div_stat_t                      div_stat;
    logic                           div_start;
    logic [NCH-1:0][PIX_W-1:0]      div_mean;

    // ------------------------------------------------------------------
    // Register writes are always taken.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_x_reg       <= RST_SCALE_X;
            scale_y_reg       <= RST_SCALE_Y;
            image_width_reg   <= RST_IMAGE_WIDTH;
            image_height_reg  <= RST_IMAGE_HEIGHT;
            channel_count_reg <= RST_CHANNEL_COUNT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SCALE_X:       scale_x_reg       <= cfg_data[SX_W-1:0];
                CFG_SCALE_Y:       scale_y_reg       <= cfg_data[SY_W-1:0];
                CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[IW_W-1:0];
                CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[IH_W-1:0];
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[NC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A zero register acts as one; values above the supported maximum act as
    // that maximum.
    always_comb begin
        if (scale_x_reg == '0) begin
            sx_m1 = '0;
        end else if (scale_x_reg > MAX_SCALE) begin
            sx_m1 = PW'(MAX_SCALE - 1);
        end else begin
            sx_m1 = PW'(scale_x_reg - 1'b1);
        end

        if (scale_y_reg == '0) begin
            sy_m1 = '0;
        end else if (scale_y_reg > MAX_SCALE) begin
            sy_m1 = PW'(MAX_SCALE - 1);
        end else begin
            sy_m1 = PW'(scale_y_reg - 1'b1);
        end

        if (image_width_reg == '0) begin
            w_m1 = '0;
        end else if (image_width_reg > MAX_WIDTH) begin
            w_m1 = CW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = CW'(image_width_reg - 1'b1);
        end

        if (image_height_reg == '0) begin
            h_m1 = '0;
        end else if (image_height_reg > MAX_HEIGHT) begin
            h_m1 = RW'(MAX_HEIGHT - 1);
        end else begin
            h_m1 = RW'(image_height_reg - 1'b1);
        end

        if (channel_count_reg == '0) begin
            nc_cl = NC_W'(1);
        end else if (channel_count_reg > NC_W'(NCH)) begin
            nc_cl = NC_W'(NCH);
        end else begin
            nc_cl = channel_count_reg;
        end
    end

    // ------------------------------------------------------------------
    // Position tracking. A segment, row or frame ends once its counter has
    // reached or passed the limit, so a smaller limit written mid-frame still
    // closes it.
    // ------------------------------------------------------------------
    assign accept    = s_tvalid && s_tready;
    assign row_end   = (pix_col_reg >= w_m1);
    assign seg_end   = row_end || (ph_col_reg >= sx_m1);
    assign vert_end  = (pix_row_reg >= h_m1) || (ph_row_reg >= sy_m1);
    assign frame_end = row_end && (pix_row_reg >= h_m1);

    assign cnt_x = {1'b0, ph_col_reg} + 1'b1;
    assign cnt_y = {1'b0, ph_row_reg} + 1'b1;
    assign n_now = DV_W'(cnt_x) * DV_W'(cnt_y);

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            part_sum[c] = part_reg[c] + PSUM_W'(s_tdata[c*PIX_W +: PIX_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_col_reg <= '0;
            pix_row_reg <= '0;
            ph_col_reg  <= '0;
            ph_row_reg  <= '0;
            blk_col_reg <= '0;
            blk_row_reg <= '0;
            part_reg    <= '0;
        end else if (accept) begin
            part_reg <= seg_end ? '0 : part_sum;
            if (row_end) begin
                pix_col_reg <= '0;
                ph_col_reg  <= '0;
                blk_col_reg <= '0;
                if (frame_end) begin
                    pix_row_reg <= '0;
                    ph_row_reg  <= '0;
                    blk_row_reg <= '0;
                end else begin
                    pix_row_reg <= pix_row_reg + 1'b1;
                    if (ph_row_reg >= sy_m1) begin
                        ph_row_reg  <= '0;
                        blk_row_reg <= blk_row_reg + 1'b1;
                    end else begin
                        ph_row_reg <= ph_row_reg + 1'b1;
                    end
                end
            end else begin
                pix_col_reg <= pix_col_reg + 1'b1;
                if (ph_col_reg >= sx_m1) begin
                    ph_col_reg  <= '0;
                    blk_col_reg <= blk_col_reg + 1'b1;
                end else begin
                    ph_col_reg <= ph_col_reg + 1'b1;
                end
            end
        end
    end

    // Everything the write-back and the division need is captured with the
    // pixel that closes the segment.
    always_ff @(posedge aclk) begin
        if (accept && seg_end) begin
            col_l_reg     <= blk_col_reg;
            first_row_reg <= (ph_row_reg == '0);
            vert_reg      <= vert_end;
            n_reg         <= n_now;
            out_col_l_reg <= OUT_COL_W'(blk_col_reg);
            out_row_l_reg <= OUT_ROW_W'(blk_row_reg);
            fend_l_reg    <= frame_end;
            seg_sum_reg   <= part_sum;
        end
    end

    // ------------------------------------------------------------------
    // Column memory: read on the closing pixel, written back in the next cycle.
    // The interface stalls during the write-back, so a read never meets a
    // pending write to the same column.
    // ------------------------------------------------------------------
    assign mem_ctl.rd_en = accept && seg_end;
    assign mem_ctl.wr_en = (state_reg == ST_ACC);
    assign col_old       = mem_rdata;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            col_new[c] = (first_row_reg ? '0 : col_old[c]) + CSUM_W'(seg_sum_reg[c]);
        end
    end

    bxds_colmem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (MEM_W)
    ) u_colmem (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .rd_addr (blk_col_reg),
        .wr_addr (col_l_reg),
        .wdata   (col_new),
        .rdata   (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Division by the pixel count that the phases of the closing pixel imply.
    // ------------------------------------------------------------------
    assign div_start = (state_reg == ST_ACC) && vert_reg;

    bxds_div #(
        .NUM_W (CSUM_W),
        .DEN_W (DV_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (col_new),
        .den     (n_reg),
        .stat    (div_stat),
        .mean    (div_mean)
    );

    // Channels beyond the channel count read as zero.
    always_comb begin
        out_word = '0;
        for (int c = 0; c < NCH; c++) begin
            if (NC_W'(c) < nc_cl) begin
                out_word[c*PIX_W +: PIX_W] = div_mean[c];
            end
        end
        out_word[IN_W +: OUT_COL_W]             = out_col_l_reg;
        out_word[IN_W + OUT_COL_W +: OUT_ROW_W] = out_row_l_reg;
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && seg_end) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                state_next = vert_reg ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A new mean may enter in the same cycle as the previous one leaves.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
                m_data_reg   <= out_word;
                m_last_reg   <= fend_l_reg;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

>>> design/bxds_chk.sv
`default_nettype none

module bxds_chk (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [bxds_pkg::IN_W-1:0]       s_tdata,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [bxds_pkg::OUT_W-1:0]      m_tdata,
    input wire logic                            m_tlast,
    input wire logic                            cfg_valid,
    input wire logic                            cfg_ready,
    input wire logic [bxds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire logic [bxds_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bxds_pkg::*;

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat present after reset");

    // The input side stalls only because a pixel was just taken.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("input stalled without a preceding pixel");

    // A new result appears only after the sequencer has held the input off.
    a_result_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared right after a pixel beat");

endmodule

bind box_average_downscaler_core bxds_chk u_bxds_chk (.*);

`default_nettype wire

>>> tb/sv/box_average_downscaler_core_tb.sv
module box_average_downscaler_core_tb;

    import bxds_pkg::*;

    // Cycles to let pass after the last expected mean before the block counts as idle.
    localparam int SETTLE_CYCLES = 40;
    // Hard stop for the whole run.
    localparam int CYCLE_LIMIT = 1500000;
    // Rough number of pixels in the randomised part.
    localparam int RANDOM_PIXELS = 400;

    // One block mean as it leaves the block. The means sit in the low bits, as on m_tdata.
    typedef struct packed {
        logic                        last;
        logic [OUT_ROW_W-1:0]        row;
        logic [OUT_COL_W-1:0]        col;
        logic [NCH-1:0][PIX_W-1:0]   mean;
    } block_mean_t;

    logic aclk = 1'b0;
    logic aresetn;

    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;     // chan0, chan1, chan2, chan3 from bit 0
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;     // mean0..mean3, out_col, out_row, zero pad from bit 0
    logic                  m_tlast;     // frame_end
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // When set, neither the pixel source nor the mean sink holds back.
    bit steady = 1'b0;

    int unsigned cycles        = 0;
    int unsigned pixels_sent   = 0;
    int unsigned means_checked = 0;
    int unsigned mismatches    = 0;
    int unsigned setups        = 0;

    // Our own copy of the block's registers, with their reset values.
    logic [SX_W-1:0] reg_sx = RST_SCALE_X;
    logic [SY_W-1:0] reg_sy = RST_SCALE_Y;
    logic [IW_W-1:0] reg_w  = RST_IMAGE_WIDTH;
    logic [IH_W-1:0] reg_h  = RST_IMAGE_HEIGHT;
    logic [NC_W-1:0] reg_nc = RST_CHANNEL_COUNT;

    // Our own copy of the accumulation state. The column sums are only ever read for
    // columns that were written on the first row of the current block row.
    int unsigned col_sum [DEF_MAX_WIDTH][NCH];
    int unsigned seg_sum [NCH];
    int unsigned pix_col = 0, pix_row = 0;
    int unsigned ph_col  = 0, ph_row  = 0;
    int unsigned blk_col = 0, blk_row = 0;

    // Means that the block still owes us, oldest first.
    block_mean_t pending_means [$];

    box_average_downscaler_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // The whole run is bounded; a stuck handshake or a missing mean ends up here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d means outstanding.",
                     cycles, pending_means.size());
            $display("FAIL box_average_downscaler_core");
            $finish;
        end
    end

    // The sink stalls at random, with a chance of about eight in a hundred.
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 8);
    end

    function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Adds one accepted pixel to the running sums and, when it is the bottom-right pixel
    // of a block, queues the mean that the block must produce. Out-of-range registers
    // act as the nearest legal value, and a register changed in mid-frame takes effect
    // at once: a segment, row or frame ends once its counter has reached or passed the
    // limit.
    task automatic accumulate_pixel(input logic [NCH-1:0][PIX_W-1:0] px);
        int unsigned sx, sy, w, h, nc, slot, count, m;
        int c;
        bit row_end, seg_end, vert_end, last;
        block_mean_t r;
        sx = clip(reg_sx, 1, DEF_MAX_SCALE);
        sy = clip(reg_sy, 1, DEF_MAX_SCALE);
        w  = clip(reg_w, 1, DEF_MAX_WIDTH);
        h  = clip(reg_h, 1, DEF_MAX_HEIGHT);
        nc = clip(reg_nc, 1, NCH);
        slot     = blk_col % DEF_MAX_WIDTH;
        row_end  = pix_col >= w - 1;
        seg_end  = row_end || ph_col >= sx - 1;
        vert_end = pix_row >= h - 1 || ph_row >= sy - 1;
        last     = row_end && pix_row >= h - 1;

        for (c = 0; c < NCH; c++)
            seg_sum[c] += px[c];

        if (seg_end) begin
            for (c = 0; c < NCH; c++) begin
                // The first row of a block row starts the column sum afresh.
                if (ph_row == 0)
                    col_sum[slot][c] = seg_sum[c];
                else
                    col_sum[slot][c] += seg_sum[c];
                seg_sum[c] = 0;
            end
            if (vert_end) begin
                // The divisor is the pixel count implied by the phases; if the scale
                // shrank in mid-block the sum may hold more pixels, hence the clamp.
                count = (ph_col + 1) * (ph_row + 1);
                for (c = 0; c < NCH; c++) begin
                    m = col_sum[slot][c] / count;
                    if (c >= nc)
                        r.mean[c] = '0;
                    else
                        r.mean[c] = (m > 255) ? 8'hFF : 8'(m);
                end
                r.col  = OUT_COL_W'(blk_col);
                r.row  = OUT_ROW_W'(blk_row);
                r.last = last;
                pending_means.push_back(r);
            end
        end

        if (row_end) begin
            pix_col = 0;
            ph_col  = 0;
            blk_col = 0;
            if (last) begin
                pix_row = 0;
                ph_row  = 0;
                blk_row = 0;
            end else begin
                pix_row++;
                if (ph_row >= sy - 1) begin
                    ph_row = 0;
                    blk_row++;
                end else begin
                    ph_row++;
                end
            end
        end else begin
            pix_col++;
            if (ph_col >= sx - 1) begin
                ph_col = 0;
                blk_col++;
            end else begin
                ph_col++;
            end
        end
    endtask

    // Offers one pixel beat, possibly after a few idle cycles, and waits for it to be taken.
    task automatic send_pixel(input logic [NCH-1:0][PIX_W-1:0] px);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        accumulate_pixel(px);
        pixels_sent++;
    endtask

    task automatic send_random_pixels(input int count, input int lo, input int hi);
        logic [NCH-1:0][PIX_W-1:0] px;
        int i, c;
        for (i = 0; i < count; i++) begin
            for (c = 0; c < NCH; c++)
                px[c] = PIX_W'($urandom_range(hi, lo));
            send_pixel(px);
        end
    endtask

    // Drops the pixel stream, lets every owed mean arrive and then lets the block finish
    // any segment write-back, so that its registers may be written safely.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_means.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The value is cut to the data width of the write channel.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SCALE_X:       reg_sx = data[SX_W-1:0];
            CFG_SCALE_Y:       reg_sy = data[SY_W-1:0];
            CFG_IMAGE_WIDTH:   reg_w  = data[IW_W-1:0];
            CFG_IMAGE_HEIGHT:  reg_h  = data[IH_W-1:0];
            CFG_CHANNEL_COUNT: reg_nc = data[NC_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int sx, input int sy, input int w, input int h, input int nc);
        settle();
        write_reg(CFG_SCALE_X, sx);
        write_reg(CFG_SCALE_Y, sy);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_CHANNEL_COUNT, nc);
        setups++;
    endtask

    // Every beat on the mean side is checked against the oldest owed mean.
    always @(posedge aclk) begin
        block_mean_t got, want;
        bit bad;
        if (aresetn && m_tvalid && m_tready) begin
            got.mean = m_tdata[IN_W-1:0];
            got.col  = m_tdata[IN_W +: OUT_COL_W];
            got.row  = m_tdata[IN_W + OUT_COL_W +: OUT_ROW_W];
            got.last = m_tlast;
            if (pending_means.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected mean beat: means %h col %0d row %0d last %b",
                             got.mean, got.col, got.row, got.last);
            end else begin
                want = pending_means.pop_front();
                means_checked++;
                bad = (got.mean !== want.mean) || (got.col !== want.col)
                   || (got.row !== want.row) || (got.last !== want.last)
                   || (m_tdata[OUT_W-1] !== 1'b0);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mean mismatch: got means %h col %0d row %0d last %b pad %b",
                                 got.mean, got.col, got.row, got.last, m_tdata[OUT_W-1]);
                        $display("               expected means %h col %0d row %0d last %b",
                                 want.mean, want.col, want.row, want.last);
                    end
                end
            end
        end
    end

    // Straight out of reset: 2x2 blocks with three channels. The first row is closed
    // after seventeen pixels by narrowing the frame, and after two blocks of the second
    // row the frame is cut short by shrinking the width below the column counter and the
    // height to the current row; the last block then holds three pixels but divides by
    // two, and with bright pixels its mean saturates.
    task automatic test_reset_defaults();
        send_random_pixels(16, 200, 255);
        settle();
        write_reg(CFG_IMAGE_WIDTH, 17);
        send_random_pixels(1 + 4, 200, 255);
        settle();
        write_reg(CFG_IMAGE_WIDTH, 1);
        write_reg(CFG_IMAGE_HEIGHT, 2);
        send_random_pixels(1, 200, 255);
    endtask

    // 1x1 blocks pass each pixel straight through; the patterns toggle every data bit.
    task automatic test_single_pixel_blocks();
        configure(1, 1, 3, 2, NCH);
        send_pixel('0);
        send_pixel('1);
        send_pixel({NCH{8'h55}});
        send_pixel({NCH{8'hAA}});
        send_pixel({NCH{8'h0F}});
        send_pixel({NCH{8'hF0}});
    endtask

    // Scales above the maximum act as the maximum, a scale of zero acts as one. The
    // first write also sets data bits above the register width, which must be dropped.
    task automatic test_scale_limits();
        configure('h1FFF, 1, 18, 1, NCH);
        send_random_pixels(18, 0, 255);
        configure(1, 31, 1, 18, NCH);
        send_random_pixels(18, 0, 255);
        configure(0, 0, 2, 2, NCH);
        send_random_pixels(4, 0, 255);
    endtask

    // Every channel count from zero up to the register's limit on a one-pixel frame.
    task automatic test_channel_counts();
        int nc;
        configure(1, 1, 1, 1, 0);
        send_pixel('1);
        for (nc = 1; nc < (1 << NC_W); nc++) begin
            settle();
            write_reg(CFG_CHANNEL_COUNT, nc);
            send_pixel('1);
        end
    endtask

    // Frames whose size is not a multiple of the block size, so edge blocks are partial.
    task automatic test_partial_edge_blocks();
        configure(2, 3, 5, 5, NCH);
        send_random_pixels(25, 0, 255);
        configure(3, 2, 7, 3, 3);
        send_random_pixels(21, 0, 255);
    endtask

    // Register writes in the middle of a frame, each chosen so that only column sums
    // written earlier in the same block row are read back.
    task automatic test_midframe_updates();
        // Narrower blocks on the second row: the column sums already hold four pixels
        // per row, so full-scale pixels give a mean that has to saturate.
        configure(4, 2, 8, 2, NCH);
        send_random_pixels(8, 255, 255);
        settle();
        write_reg(CFG_SCALE_X, 2);
        write_reg(CFG_IMAGE_WIDTH, 4);
        send_random_pixels(2, 255, 255);
        settle();
        write_reg(CFG_CHANNEL_COUNT, 2);
        send_random_pixels(2, 255, 255);

        // Shorter blocks once the vertical phase has already passed the new limit.
        configure(1, 4, 2, 6, NCH);
        send_random_pixels(4, 0, 255);
        settle();
        write_reg(CFG_SCALE_Y, 2);
        send_random_pixels(8, 0, 255);

        // Height reduced below the current row: the frame closes at the end of that row.
        configure(2, 2, 4, 8, NCH);
        send_random_pixels(12, 0, 255);
        settle();
        write_reg(CFG_IMAGE_HEIGHT, 2);
        send_random_pixels(4, 0, 255);
    endtask

    // Writes to indexes beyond the register list must change nothing.
    task automatic test_unused_register_indexes();
        int idx;
        configure(1, 1, 2, 1, NCH);
        for (idx = int'(CFG_CHANNEL_COUNT) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), -1);
        send_random_pixels(2, 0, 255);
    endtask

    // A width above the maximum acts as the maximum, so a long row runs on without
    // ending; it is then closed by narrowing the frame. One mean per pixel, and neither
    // the source nor the sink holds back during the row.
    task automatic test_widest_row();
        configure(1, 1, 'h1FFF, 1, NCH);
        steady = 1'b1;
        send_random_pixels(128, 0, 255);
        steady = 1'b0;
        settle();
        write_reg(CFG_IMAGE_WIDTH, 1);
        send_random_pixels(1, 0, 255);
    endtask

    // A height above the maximum on a one-pixel-wide frame (width written as zero), one
    // mean per row; the frame is then closed by lowering the height.
    task automatic test_tallest_column();
        configure(1, 0, 0, 'h1FFF, 2);
        send_random_pixels(40, 0, 255);
        settle();
        write_reg(CFG_IMAGE_HEIGHT, 1);
        send_random_pixels(1, 0, 255);
    endtask

    function automatic logic [NCH-1:0][PIX_W-1:0] random_pixel();
        logic [NCH-1:0][PIX_W-1:0] px;
        case ($urandom_range(9))
            0: px = '0;
            1: px = '1;
            default: px = $urandom;
        endcase
        return px;
    endfunction

    // Whole frames of random size, scale and channel count with random pixels. Now and
    // then a frame is broken off: the height is cut to one row in mid-frame and only the
    // rest of the current row is sent, which closes the frame early.
    task automatic test_random_frames();
        int unsigned start, total, cut, left, i;
        int sx, sy;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS) begin
            sx = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(4, 1);
            sy = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(4, 1);
            configure(sx, sy, $urandom_range(24), $urandom_range(10), $urandom_range(7));
            total = clip(reg_w, 1, DEF_MAX_WIDTH) * clip(reg_h, 1, DEF_MAX_HEIGHT);
            cut = total;
            if (total > 1 && $urandom_range(5) == 0)
                cut = $urandom_range(total - 1, 1);
            for (i = 0; i < cut; i++)
                send_pixel(random_pixel());
            if (cut < total) begin
                settle();
                write_reg(CFG_IMAGE_HEIGHT, 1);
                write_reg(CFG_CHANNEL_COUNT, $urandom_range(7));
                left = clip(reg_w, 1, DEF_MAX_WIDTH) - pix_col;
                for (i = 0; i < left; i++)
                    send_pixel(random_pixel());
            end
        end
    endtask

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        aresetn   = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_single_pixel_blocks();
        test_scale_limits();
        test_channel_counts();
        test_partial_edge_blocks();
        test_midframe_updates();
        test_unused_register_indexes();
        test_widest_row();
        test_tallest_column();
        test_random_frames();

        settle();
        $display("Streamed %0d pixels over %0d register setups, including mid-frame changes",
                 pixels_sent, setups);
        $display("and frame sizes above the maximum; %0d block means checked.",
                 means_checked);
        if (mismatches == 0) begin
            $display("PASS box_average_downscaler_core");
        end else begin
            $display("%0d block means were wrong or unexpected.", mismatches);
            $display("FAIL box_average_downscaler_core");
        end
        $finish;
    end

endmodule
